// ----- sv/tlc_pkg.sv -----
`default_nettype none

package tlc_pkg;

    localparam int SAMPLE_WIDTH    = 12;
    localparam int BUTTON_WIDTH    = 10;
    localparam int SECS_WIDTH      = 7;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int MS_PER_SECOND   = 1000;

    localparam int RED_RESET_MS       = 5000;
    localparam int YELLOW_RESET_MS    = 2000;
    localparam int GREEN_RESET_MS     = 5000;
    localparam int BLINK_RESET_MS     = 500;
    localparam int THRESHOLD_RESET    = 1000;
    localparam int SHORTEN_RESET_MS   = 2000;
    localparam int BUTTON_SAMPLE_RESET = 50;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_RED_TIME      = 3'd0,
        REG_YELLOW_TIME   = 3'd1,
        REG_GREEN_TIME    = 3'd2,
        REG_BLINK_TIME    = 3'd3,
        REG_THRESHOLD     = 3'd4,
        REG_SHORTEN_TIME  = 3'd5,
        REG_BUTTON_SAMPLE = 3'd6
    } cfg_reg_t;

    typedef enum logic [3:0] {
        MODE_GREEN  = 4'b0001,
        MODE_YELLOW = 4'b0010,
        MODE_RED    = 4'b0100,
        MODE_NIGHT  = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] light_level;
        logic                    button_pressed;
    } tick_t;

    typedef struct packed {
        logic                  red_lamp;
        logic                  yellow_lamp;
        logic                  green_lamp;
        logic                  walk_lamp;
        logic [SECS_WIDTH-1:0] seconds_left;
        logic                  display_blank;
    } lamp_t;

endpackage

`default_nettype wire

// ----- sv/traffic_light_controller.sv -----
// Three register stages: tick register, phase/state update, countdown multiply.
// An accepted tick moves through the tick register, the state update and the output register
// to lamp_valid. Throughput: one tick per cycle; a stalled result holds the whole pipe.
// Reset (rst_n, asynchronous, active low) empties the pipe, restores the default
// timings and starts in green with all timers at zero.
`default_nettype none

module traffic_light_controller #(
    parameter  int TIME_WIDTH = 16,
    localparam int CFG_WIDTH_A = (TIME_WIDTH > tlc_pkg::SAMPLE_WIDTH) ?
                                 TIME_WIDTH : tlc_pkg::SAMPLE_WIDTH,
    localparam int CFG_WIDTH = (CFG_WIDTH_A > tlc_pkg::BUTTON_WIDTH) ?
                               CFG_WIDTH_A : tlc_pkg::BUTTON_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                tick_valid,
    output logic                                tick_stall,
    input  tlc_pkg::tick_t                      tick_data,
    output logic                                lamp_valid,
    input  logic                                lamp_stall,
    output tlc_pkg::lamp_t                      lamp_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tlc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]                cfg_data
);

    localparam int BW = tlc_pkg::BUTTON_WIDTH;
    localparam int SW = tlc_pkg::SAMPLE_WIDTH;

    // configuration
    logic [TIME_WIDTH-1:0] red_time_reg;
    logic [TIME_WIDTH-1:0] yellow_time_reg;
    logic [TIME_WIDTH-1:0] green_time_reg;
    logic [TIME_WIDTH-1:0] blink_time_reg;
    logic [SW-1:0]         threshold_reg;
    logic [TIME_WIDTH-1:0] shorten_time_reg;
    logic [BW-1:0]         button_sample_reg;

    // controller state
    tlc_pkg::mode_t        mode_reg;
    tlc_pkg::mode_t        mode_next;
    logic [TIME_WIDTH-1:0] elapsed_reg;
    logic [TIME_WIDTH-1:0] elapsed_next;
    logic [BW-1:0]         button_timer_reg;
    logic [BW-1:0]         button_timer_next;
    logic [TIME_WIDTH-1:0] blink_timer_reg;
    logic [TIME_WIDTH-1:0] blink_timer_next;
    logic                  blink_phase_reg;
    logic                  blink_phase_next;
    logic                  night_yellow_reg;
    logic                  night_yellow_next;

    // pipeline
    logic                  enable;
    logic                  tick_valid_reg;
    tlc_pkg::tick_t        tick_reg;
    logic                  mid_valid_reg;
    tlc_pkg::lamp_t        mid_lamp_reg;
    tlc_pkg::lamp_t        mid_lamp_next;
    logic [TIME_WIDTH-1:0] mid_remaining_reg;
    logic [TIME_WIDTH-1:0] mid_remaining_next;
    logic                  out_valid_reg;
    tlc_pkg::lamp_t        out_lamp_reg;
    tlc_pkg::lamp_t        out_lamp_next;
    logic [tlc_pkg::SECS_WIDTH-1:0] seconds;

    logic                  dark;
    logic [TIME_WIDTH:0]   cut_sum;
    logic [TIME_WIDTH-1:0] duration;

    function automatic logic [TIME_WIDTH-1:0] duration_of(
        input tlc_pkg::mode_t        m,
        input logic [TIME_WIDTH-1:0] r,
        input logic [TIME_WIDTH-1:0] y,
        input logic [TIME_WIDTH-1:0] g
    );
        logic [TIME_WIDTH-1:0] d;
        case (m)
            tlc_pkg::MODE_GREEN:  d = g;
            tlc_pkg::MODE_YELLOW: d = y;
            default:              d = r;
        endcase
        return d;
    endfunction

    assign enable     = !out_valid_reg || !lamp_stall;
    assign tick_stall = !enable;
    assign cfg_ready  = 1'b1;
    assign lamp_valid = out_valid_reg;
    assign lamp_data  = out_lamp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_time_reg      <= TIME_WIDTH'(tlc_pkg::RED_RESET_MS);
            yellow_time_reg   <= TIME_WIDTH'(tlc_pkg::YELLOW_RESET_MS);
            green_time_reg    <= TIME_WIDTH'(tlc_pkg::GREEN_RESET_MS);
            blink_time_reg    <= TIME_WIDTH'(tlc_pkg::BLINK_RESET_MS);
            threshold_reg     <= SW'(tlc_pkg::THRESHOLD_RESET);
            shorten_time_reg  <= TIME_WIDTH'(tlc_pkg::SHORTEN_RESET_MS);
            button_sample_reg <= BW'(tlc_pkg::BUTTON_SAMPLE_RESET);
        end
        else if (cfg_valid)
        begin
            case (tlc_pkg::cfg_reg_t'(cfg_index))
                tlc_pkg::REG_RED_TIME:      red_time_reg      <= cfg_data[TIME_WIDTH-1:0];
                tlc_pkg::REG_YELLOW_TIME:   yellow_time_reg   <= cfg_data[TIME_WIDTH-1:0];
                tlc_pkg::REG_GREEN_TIME:    green_time_reg    <= cfg_data[TIME_WIDTH-1:0];
                tlc_pkg::REG_BLINK_TIME:    blink_time_reg    <= cfg_data[TIME_WIDTH-1:0];
                tlc_pkg::REG_THRESHOLD:     threshold_reg     <= cfg_data[SW-1:0];
                tlc_pkg::REG_SHORTEN_TIME:  shorten_time_reg  <= cfg_data[TIME_WIDTH-1:0];
                tlc_pkg::REG_BUTTON_SAMPLE: button_sample_reg <= cfg_data[BW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        mode_next          = mode_reg;
        elapsed_next       = elapsed_reg;
        button_timer_next  = button_timer_reg;
        blink_timer_next   = blink_timer_reg;
        blink_phase_next   = blink_phase_reg;
        night_yellow_next  = night_yellow_reg;
        mid_lamp_next      = '0;
        mid_remaining_next = '0;
        duration           = '0;

        dark = tick_reg.light_level < threshold_reg;
        if (dark)
        begin
            if (mode_reg != tlc_pkg::MODE_NIGHT)
                night_yellow_next = 1'b0;
            mode_next = tlc_pkg::MODE_NIGHT;
        end
        else if (mode_reg == tlc_pkg::MODE_NIGHT)
        begin
            mode_next    = tlc_pkg::MODE_RED;
            elapsed_next = '0;
        end

        // remaining green exceeds the cut time exactly when elapsed + cut < green
        cut_sum = {1'b0, elapsed_next} + {1'b0, shorten_time_reg};
        if (button_timer_reg > button_sample_reg)
        begin
            button_timer_next = '0;
            if (tick_reg.button_pressed && mode_next == tlc_pkg::MODE_GREEN &&
                cut_sum < {1'b0, green_time_reg})
                elapsed_next = green_time_reg - shorten_time_reg;
        end

        if (mode_next == tlc_pkg::MODE_NIGHT)
        begin
            if (blink_timer_reg >= blink_time_reg)
            begin
                blink_timer_next  = '0;
                blink_phase_next  = ~blink_phase_reg;
                night_yellow_next = ~blink_phase_reg;
            end
            mid_lamp_next.yellow_lamp   = night_yellow_next;
            mid_lamp_next.display_blank = 1'b1;
        end
        else
        begin
            duration = duration_of(mode_next, red_time_reg, yellow_time_reg, green_time_reg);
            if (elapsed_next >= duration)
            begin
                elapsed_next = '0;
                case (mode_next)
                    tlc_pkg::MODE_GREEN:  mode_next = tlc_pkg::MODE_YELLOW;
                    tlc_pkg::MODE_YELLOW: mode_next = tlc_pkg::MODE_RED;
                    default:              mode_next = tlc_pkg::MODE_GREEN;
                endcase
                duration = duration_of(mode_next, red_time_reg, yellow_time_reg,
                                       green_time_reg);
            end
            case (mode_next)
                tlc_pkg::MODE_GREEN:  mid_lamp_next.green_lamp  = 1'b1;
                tlc_pkg::MODE_YELLOW: mid_lamp_next.yellow_lamp = 1'b1;
                default:
                begin
                    mid_lamp_next.red_lamp  = 1'b1;
                    mid_lamp_next.walk_lamp = 1'b1;
                end
            endcase
            if (elapsed_next < duration)
                mid_remaining_next = duration - elapsed_next;
        end

        if (!(&elapsed_next))
            elapsed_next = elapsed_next + TIME_WIDTH'(1);
        if (!(&button_timer_next))
            button_timer_next = button_timer_next + BW'(1);
        if (!(&blink_timer_next))
            blink_timer_next = blink_timer_next + TIME_WIDTH'(1);
    end

    tlc_countdown #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_countdown (
        .remaining (mid_remaining_reg),
        .seconds   (seconds)
    );

    always_comb
    begin
        out_lamp_next = mid_lamp_reg;
        if (mid_lamp_reg.display_blank)
            out_lamp_next.seconds_left = '0;
        else
            out_lamp_next.seconds_left = seconds;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= tlc_pkg::MODE_GREEN;
            elapsed_reg      <= '0;
            button_timer_reg <= '0;
            blink_timer_reg  <= '0;
            blink_phase_reg  <= 1'b0;
            night_yellow_reg <= 1'b0;
            tick_valid_reg   <= 1'b0;
            mid_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else if (enable)
        begin
            tick_valid_reg <= tick_valid;
            mid_valid_reg  <= tick_valid_reg;
            out_valid_reg  <= mid_valid_reg;
            if (tick_valid_reg)
            begin
                mode_reg         <= mode_next;
                elapsed_reg      <= elapsed_next;
                button_timer_reg <= button_timer_next;
                blink_timer_reg  <= blink_timer_next;
                blink_phase_reg  <= blink_phase_next;
                night_yellow_reg <= night_yellow_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            tick_reg          <= tick_data;
            mid_lamp_reg      <= mid_lamp_next;
            mid_remaining_reg <= mid_remaining_next;
            out_lamp_reg      <= out_lamp_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/tlc_countdown.sv -----
`default_nettype none

// whole seconds left plus one, via exact reciprocal multiply
module tlc_countdown #(
    parameter int TIME_WIDTH = 16
) (
    input  logic [TIME_WIDTH-1:0]          remaining,
    output logic [tlc_pkg::SECS_WIDTH-1:0] seconds
);

    localparam int SHIFT = TIME_WIDTH + 10;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(tlc_pkg::MS_PER_SECOND - 1)) / 64'(tlc_pkg::MS_PER_SECOND);
    localparam logic [TIME_WIDTH:0] RECIP = RECIP_FULL[TIME_WIDTH:0];

    logic [2*TIME_WIDTH:0] product;
    logic [2*TIME_WIDTH:0] quotient;

    assign product  = {{(TIME_WIDTH + 1){1'b0}}, remaining} *
                      {{TIME_WIDTH{1'b0}}, RECIP};
    assign quotient = product >> SHIFT;
    assign seconds  = quotient[tlc_pkg::SECS_WIDTH-1:0] + tlc_pkg::SECS_WIDTH'(1);

endmodule

`default_nettype wire

// ----- bench/traffic_light_controller_test.sv -----
`timescale 1ns / 1ps

module traffic_light_controller_test;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 14;
    localparam int DRAIN_CYCLES   = 8;
    localparam int REPORT_LIMIT   = 10;
    localparam int SCRIPT_ROWS    = 25;

    localparam logic [tlc_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;

    // register field of a tick row, never written
    localparam tlc_pkg::cfg_reg_t TICK_ROW_REG = tlc_pkg::REG_RED_TIME;

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

    typedef struct packed {
        row_kind_t         kind;
        tlc_pkg::cfg_reg_t reg_idx;
        logic [15:0]       reg_val;
        tlc_pkg::tick_t    tick;
        logic              typed;
        tlc_pkg::lamp_t    lamps;
    } step_t;

    localparam tlc_pkg::lamp_t NO_LAMPS       = '0;
    localparam tlc_pkg::lamp_t LAMPS_DARK     = '{1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 1'b1};
    localparam tlc_pkg::lamp_t LAMPS_GREEN_6  = '{1'b0, 1'b0, 1'b1, 1'b0, 7'd6, 1'b0};
    localparam tlc_pkg::lamp_t LAMPS_RED_6    = '{1'b1, 1'b0, 1'b0, 1'b1, 7'd6, 1'b0};
    localparam tlc_pkg::lamp_t LAMPS_GREEN_66 = '{1'b0, 1'b0, 1'b1, 1'b0, 7'd66, 1'b0};

    logic           clk        = 1'b0;
    logic           rst_n      = 1'b0;
    logic           tick_valid = 1'b0;
    logic           tick_stall;
    tlc_pkg::tick_t tick_data  = '0;
    logic           lamp_valid;
    logic           lamp_stall = 1'b0;
    tlc_pkg::lamp_t lamp_data;
    logic           cfg_valid  = 1'b0;
    logic           cfg_ready;
    logic [tlc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [15:0]    cfg_data   = '0;

    // predictor state and register copy
    tlc_pkg::mode_t    ctl_mode;
    logic [15:0]       elapsed;
    logic [tlc_pkg::BUTTON_WIDTH-1:0] btn_timer;
    logic [15:0]       blink_timer;
    logic              blink_phase;
    logic              night_yellow;
    logic [15:0]       red_ms;
    logic [15:0]       yellow_ms;
    logic [15:0]       green_ms;
    logic [15:0]       blink_ms;
    logic [15:0]       shorten_ms;
    logic [tlc_pkg::SAMPLE_WIDTH-1:0] thresh;
    logic [tlc_pkg::BUTTON_WIDTH-1:0] sample_ms;

    tlc_pkg::lamp_t lamp_due [$];
    tlc_pkg::lamp_t want;
    step_t script [SCRIPT_ROWS];

    int mismatches    = 0;
    int results_seen  = 0;
    int ticks_sent    = 0;
    int reg_writes    = 0;
    int settings_used = 0;
    int phase_changes = 0;
    int night_ticks   = 0;
    int green_cuts    = 0;
    int burst_left    = 0;
    int idle_cycles   = 0;
    int stall_left    = 0;
    stall_style_t stall_style = STALL_NONE;

    traffic_light_controller i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .tick_data  (tick_data),
        .lamp_valid (lamp_valid),
        .lamp_stall (lamp_stall),
        .lamp_data  (lamp_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int phase_length(tlc_pkg::mode_t m);
        case (m)
            tlc_pkg::MODE_GREEN:  return int'(green_ms);
            tlc_pkg::MODE_YELLOW: return int'(yellow_ms);
            default:              return int'(red_ms);
        endcase
    endfunction

    function automatic tlc_pkg::lamp_t advance_lights(tlc_pkg::tick_t t);
        tlc_pkg::lamp_t o;
        int             dur;
        int             el;
        int             rem;
        o = '0;
        if (t.light_level < thresh)
        begin
            if (ctl_mode != tlc_pkg::MODE_NIGHT)
            begin
                ctl_mode     = tlc_pkg::MODE_NIGHT;
                night_yellow = 1'b0;
            end
        end
        else if (ctl_mode == tlc_pkg::MODE_NIGHT)
        begin
            ctl_mode = tlc_pkg::MODE_RED;
            elapsed  = '0;
        end
        if (btn_timer > sample_ms)
        begin
            btn_timer = '0;
            if (t.button_pressed && ctl_mode == tlc_pkg::MODE_GREEN)
            begin
                rem = (elapsed < green_ms) ? int'(green_ms) - int'(elapsed) : 0;
                if (rem > int'(shorten_ms))
                begin
                    elapsed = green_ms - shorten_ms;
                    green_cuts++;
                end
            end
        end
        if (ctl_mode == tlc_pkg::MODE_NIGHT)
        begin
            if (blink_timer >= blink_ms)
            begin
                blink_timer  = '0;
                blink_phase  = ~blink_phase;
                night_yellow = blink_phase;
            end
            o.yellow_lamp   = night_yellow;
            o.display_blank = 1'b1;
            night_ticks++;
        end
        else
        begin
            dur = phase_length(ctl_mode);
            el  = int'(elapsed);
            if (el >= dur)
            begin
                elapsed = '0;
                el      = 0;
                case (ctl_mode)
                    tlc_pkg::MODE_GREEN:  ctl_mode = tlc_pkg::MODE_YELLOW;
                    tlc_pkg::MODE_YELLOW: ctl_mode = tlc_pkg::MODE_RED;
                    default:              ctl_mode = tlc_pkg::MODE_GREEN;
                endcase
                dur = phase_length(ctl_mode);
                phase_changes++;
            end
            o.green_lamp   = (ctl_mode == tlc_pkg::MODE_GREEN);
            o.yellow_lamp  = (ctl_mode == tlc_pkg::MODE_YELLOW);
            o.red_lamp     = (ctl_mode == tlc_pkg::MODE_RED);
            o.walk_lamp    = (ctl_mode == tlc_pkg::MODE_RED);
            rem            = (el < dur) ? dur - el : 0;
            o.seconds_left = tlc_pkg::SECS_WIDTH'(rem / tlc_pkg::MS_PER_SECOND + 1);
        end
        if (elapsed != '1)
            elapsed = elapsed + 1'b1;
        if (btn_timer != '1)
            btn_timer = btn_timer + 1'b1;
        if (blink_timer != '1)
            blink_timer = blink_timer + 1'b1;
        return o;
    endfunction

    task automatic send_tick(tlc_pkg::tick_t t, logic typed, tlc_pkg::lamp_t given);
        tlc_pkg::lamp_t predicted;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                      : $urandom_range(1, 30);
            repeat ($urandom_range(0, 8))
            begin
                tick_valid <= 1'b0;
                @(negedge clk);
            end
        end
        burst_left--;
        tick_valid <= 1'b1;
        tick_data  <= t;
        do
            @(posedge clk);
        while (tick_stall);
        predicted = advance_lights(t);
        lamp_due.push_back(typed ? given : predicted);
        ticks_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        tick_valid <= 1'b0;
        while (lamp_due.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [tlc_pkg::CFG_INDEX_WIDTH-1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            tlc_pkg::REG_RED_TIME:      red_ms     = val;
            tlc_pkg::REG_YELLOW_TIME:   yellow_ms  = val;
            tlc_pkg::REG_GREEN_TIME:    green_ms   = val;
            tlc_pkg::REG_BLINK_TIME:    blink_ms   = val;
            tlc_pkg::REG_THRESHOLD:     thresh     = val[tlc_pkg::SAMPLE_WIDTH-1:0];
            tlc_pkg::REG_SHORTEN_TIME:  shorten_ms = val;
            tlc_pkg::REG_BUTTON_SAMPLE: sample_ms  = val[tlc_pkg::BUTTON_WIDTH-1:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // receiver back-pressure, switching style every so often
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style = stall_style_t'($urandom_range(0, 3));
            stall_left  = $urandom_range(10, 200);
        end
        stall_left--;
        case (stall_style)
            STALL_NONE:  lamp_stall <= 1'b0;
            STALL_LIGHT: lamp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: lamp_stall <= ($urandom_range(0, 3) != 0);
            default:     lamp_stall <= ((stall_left % 8) < 3);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && lamp_valid && !lamp_stall)
        begin
            results_seen++;
            if (lamp_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected lamp transaction: r%b y%b g%b w%b s%0d b%b",
                             lamp_data.red_lamp, lamp_data.yellow_lamp,
                             lamp_data.green_lamp, lamp_data.walk_lamp,
                             lamp_data.seconds_left, lamp_data.display_blank);
            end
            else
            begin
                want = lamp_due.pop_front();
                if (lamp_data.red_lamp !== want.red_lamp
                    || lamp_data.yellow_lamp !== want.yellow_lamp
                    || lamp_data.green_lamp !== want.green_lamp
                    || lamp_data.walk_lamp !== want.walk_lamp
                    || lamp_data.seconds_left !== want.seconds_left
                    || lamp_data.display_blank !== want.display_blank)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $write("lamp mismatch at transaction %0d: expected r%b y%b g%b w%b s%0d b%b, ",
                               results_seen,
                               want.red_lamp, want.yellow_lamp, want.green_lamp,
                               want.walk_lamp, want.seconds_left, want.display_blank);
                        $display("got r%b y%b g%b w%b s%0d b%b",
                                 lamp_data.red_lamp, lamp_data.yellow_lamp,
                                 lamp_data.green_lamp, lamp_data.walk_lamp,
                                 lamp_data.seconds_left, lamp_data.display_blank);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (tick_valid && !tick_stall) || (lamp_valid && !lamp_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("FAIL traffic_light_controller");
            $finish;
        end
    end

    initial
    begin
        logic [15:0]    vals [7];
        tlc_pkg::tick_t t;
        int             n;
        int             lvl;
        int             light_run;
        int             button_run;
        logic           in_dark;
        logic           held;

        light_run  = 0;
        button_run = 0;
        in_dark    = 1'b0;
        held       = 1'b0;

        red_ms       = 16'(tlc_pkg::RED_RESET_MS);
        yellow_ms    = 16'(tlc_pkg::YELLOW_RESET_MS);
        green_ms     = 16'(tlc_pkg::GREEN_RESET_MS);
        blink_ms     = 16'(tlc_pkg::BLINK_RESET_MS);
        thresh       = tlc_pkg::SAMPLE_WIDTH'(tlc_pkg::THRESHOLD_RESET);
        shorten_ms   = 16'(tlc_pkg::SHORTEN_RESET_MS);
        sample_ms    = tlc_pkg::BUTTON_WIDTH'(tlc_pkg::BUTTON_SAMPLE_RESET);
        ctl_mode     = tlc_pkg::MODE_GREEN;
        elapsed      = '0;
        btn_timer    = '0;
        blink_timer  = '0;
        blink_phase  = 1'b0;
        night_yellow = 1'b0;

        script[0]  = '{ROW_TICK, TICK_ROW_REG, 16'd0, '{12'd4095, 1'b0}, 1'b1, LAMPS_GREEN_6};
        script[1]  = '{ROW_TICK, TICK_ROW_REG, 16'd0, '{12'd0, 1'b1}, 1'b1, LAMPS_DARK};
        script[2]  = '{ROW_TICK, TICK_ROW_REG, 16'd0, '{12'd999, 1'b0}, 1'b1, LAMPS_DARK};
        script[3]  = '{ROW_TICK, TICK_ROW_REG, 16'd0, '{12'd1000, 1'b1}, 1'b1, LAMPS_RED_6};
        script[4]  = '{ROW_WRITE, tlc_pkg::REG_RED_TIME, 16'd0, '0, 1'b0, NO_LAMPS};
        script[5]  = '{ROW_WRITE, tlc_pkg::REG_YELLOW_TIME, 16'd1, '0, 1'b0, NO_LAMPS};
        script[6]  = '{ROW_WRITE, tlc_pkg::REG_GREEN_TIME, 16'hFFFF, '0, 1'b0, NO_LAMPS};
        script[7]  = '{ROW_WRITE, tlc_pkg::REG_BUTTON_SAMPLE, 16'd0, '0, 1'b0, NO_LAMPS};
        script[8]  = '{ROW_WRITE, tlc_pkg::REG_SHORTEN_TIME, 16'd3, '0, 1'b0, NO_LAMPS};
        script[9]  = '{ROW_WRITE, tlc_pkg::REG_BLINK_TIME, 16'd1, '0, 1'b0, NO_LAMPS};
        script[10] = '{ROW_WRITE, tlc_pkg::REG_THRESHOLD, 16'd4095, '0, 1'b0, NO_LAMPS};
        script[11] = '{ROW_TICK, TICK_ROW_REG, 16'd0, '{12'd4095, 1'b0}, 1'b1, LAMPS_GREEN_66};
        script[12] = '{ROW_TICK, TICK_ROW_REG, 16'd0, '{12'd4095, 1'b1}, 1'b0, NO_LAMPS};
        script[13] = '{ROW_TICK, TICK_ROW_REG, 16'd0, '{12'd4095, 1'b1}, 1'b0, NO_LAMPS};
        script[14] = '{ROW_TICK, TICK_ROW_REG, 16'd0, '{12'd4095, 1'b0}, 1'b0, NO_LAMPS};
        script[15] = '{ROW_TICK, TICK_ROW_REG, 16'd0, '{12'd4095, 1'b0}, 1'b0, NO_LAMPS};
        script[16] = '{ROW_TICK, TICK_ROW_REG, 16'd0, '{12'd4095, 1'b0}, 1'b0, NO_LAMPS};
        script[17] = '{ROW_TICK, TICK_ROW_REG, 16'd0, '{12'd4094, 1'b0}, 1'b0, NO_LAMPS};
        script[18] = '{ROW_TICK, TICK_ROW_REG, 16'd0, '{12'd0, 1'b0}, 1'b0, NO_LAMPS};
        script[19] = '{ROW_TICK, TICK_ROW_REG, 16'd0, '{12'd2048, 1'b1}, 1'b0, NO_LAMPS};
        script[20] = '{ROW_TICK, TICK_ROW_REG, 16'd0, '{12'd4095, 1'b0}, 1'b0, NO_LAMPS};
        script[21] = '{ROW_WRITE, tlc_pkg::REG_BUTTON_SAMPLE, 16'd1023, '0, 1'b0, NO_LAMPS};
        script[22] = '{ROW_WRITE, tlc_pkg::REG_THRESHOLD, 16'd0, '0, 1'b0, NO_LAMPS};
        script[23] = '{ROW_WRITE, tlc_pkg::REG_SHORTEN_TIME, 16'hFFFF, '0, 1'b0, NO_LAMPS};
        script[24] = '{ROW_TICK, TICK_ROW_REG, 16'd0, '{12'd0, 1'b1}, 1'b0, NO_LAMPS};

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part, starting from the reset timings
        settings_used = 1;
        foreach (script[i])
        begin
            if (script[i].kind == ROW_WRITE)
            begin
                drain();
                write_reg(script[i].reg_idx, script[i].reg_val);
            end
            else
                send_tick(script[i].tick, script[i].typed, script[i].lamps);
        end

        // register order: red, yellow, green, blink, threshold, shorten, sample
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: vals = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd2048, 16'd0, 16'd0};
                1: vals = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd4095, 16'hFFFF, 16'd1023};
                2: vals = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0};
                default:
                begin
                    foreach (vals[r])
                        vals[r] = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                               : 16'($urandom_range(0, 40));
                    if ($urandom_range(0, 7) != 0)
                        vals[tlc_pkg::REG_THRESHOLD] = 16'($urandom_range(0, 4095));
                    if ($urandom_range(0, 7) != 0)
                        vals[tlc_pkg::REG_BUTTON_SAMPLE] = 16'($urandom_range(0, 6));
                end
            endcase
            drain();
            foreach (vals[r])
                write_reg(tlc_pkg::CFG_INDEX_WIDTH'(r), vals[r]);
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_UNUSED, 16'($urandom));
            settings_used++;

            n = $urandom_range(50, 90);
            repeat (n)
            begin
                if (light_run == 0)
                begin
                    in_dark   = ($urandom_range(0, 2) == 0);
                    light_run = in_dark ? $urandom_range(1, 25) : $urandom_range(5, 80);
                end
                light_run--;
                if (button_run == 0)
                begin
                    held       = $urandom_range(0, 1);
                    button_run = $urandom_range(1, 30);
                end
                button_run--;
                if ($urandom_range(0, 9) == 0)
                    lvl = $urandom_range(0, 4095);
                else if (in_dark && thresh != 0)
                    lvl = ($urandom_range(0, 7) == 0) ? int'(thresh) - 1
                                                       : $urandom_range(0, int'(thresh) - 1);
                else if (!in_dark)
                    lvl = ($urandom_range(0, 7) == 0) ? int'(thresh)
                                                       : $urandom_range(int'(thresh), 4095);
                else
                    lvl = $urandom_range(0, 4095);
                t.light_level    = tlc_pkg::SAMPLE_WIDTH'(lvl);
                t.button_pressed = held;
                send_tick(t, 1'b0, NO_LAMPS);
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        mismatches += lamp_due.size();

        $display("%0d tick transactions checked across %0d register settings (%0d writes)",
                 ticks_sent, settings_used, reg_writes);
        $display("%0d phase changes, %0d night ticks, %0d green phases cut by the button",
                 phase_changes, night_ticks, green_cuts);
        if (mismatches == 0)
            $display("PASS traffic_light_controller");
        else
            $display("FAIL traffic_light_controller");
        $finish;
    end

endmodule
